@@ rtl/tftp_pkg.sv @@
// ----------------------------------------------------------------------------
// tftp_pkg
// Shared widths, codes, reset values and beat types of the TFTP session block.
// ----------------------------------------------------------------------------
package tftp_pkg;

   localparam int unsigned OP_W            = 16;
   localparam int unsigned BLK_W           = 16;
   localparam int unsigned LEN_W           = 10;
   localparam int unsigned TIMEOUT_W       = 16;
   localparam int unsigned RETRY_W         = 8;
   localparam int unsigned CSR_INDEX_W     = 1;
   localparam int unsigned CSR_DATA_W      = 16;

   localparam int unsigned BLOCK_BYTES_DEF = 512;
   localparam int unsigned HDR_BYTES       = 4;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = TIMEOUT_W'(5000);
   localparam logic [RETRY_W-1:0]   MAX_RETRIES_RESET = RETRY_W'(5);
   localparam logic [RETRY_W-1:0]   RETRY_SAT         = '1;

   localparam logic [OP_W-1:0] OP_RRQ  = OP_W'(1);
   localparam logic [OP_W-1:0] OP_WRQ  = OP_W'(2);
   localparam logic [OP_W-1:0] OP_DATA = OP_W'(3);
   localparam logic [OP_W-1:0] OP_ACK  = OP_W'(4);

   typedef enum logic {
      CMD_PACKET = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT     = 1'b0,
      CSR_MAX_RETRIES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_ERROR  = 3'd1,
      KIND_ACK    = 3'd2,
      KIND_DATA   = 3'd3,
      KIND_RESEND = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_ACCESS    = 2'd0,
      ERR_NOT_FOUND = 2'd1,
      ERR_BLOCK     = 2'd2,
      ERR_ILLEGAL   = 2'd3
   } err_type;

   typedef struct packed {
      logic             command;
      logic [OP_W-1:0]  opcode;
      logic [BLK_W-1:0] block;
      logic [LEN_W-1:0] payload_len;
      logic             open_ok;
      logic             read_ok;
      logic [LEN_W-1:0] read_len;
      logic             write_ok;
   } req_item_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic             to_requester;
      logic [1:0]       error_code;
      logic [BLK_W-1:0] block_out;
      logic [LEN_W-1:0] packet_len;
      logic             session_open;
   } rsp_item_type;

   // Saturate a length at the block size.
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                  input int unsigned limit);
      logic [LEN_W-1:0] r;
      r = v;
      if (int'(v) > int'(limit)) begin
         r = LEN_W'(limit);
      end
      return r;
   endfunction

endpackage

@@ rtl/tftp_req_if.sv @@
// ----------------------------------------------------------------------------
// tftp_req_if
// Request channel: one received packet header or one millisecond tick a beat.
// ----------------------------------------------------------------------------
interface tftp_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [tftp_pkg::OP_W-1:0]    opcode;
   logic [tftp_pkg::BLK_W-1:0]   block;
   logic [tftp_pkg::LEN_W-1:0]   payload_len;
   logic                         open_ok;
   logic                         read_ok;
   logic [tftp_pkg::LEN_W-1:0]   read_len;
   logic                         write_ok;

   modport source (
      output valid, command, opcode, block, payload_len, open_ok, read_ok,
             read_len, write_ok,
      input  ready
   );

   modport sink (
      input  valid, command, opcode, block, payload_len, open_ok, read_ok,
             read_len, write_ok,
      output ready
   );
endinterface

@@ rtl/tftp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tftp_rsp_if
// Response channel: one send decision a beat.
// ----------------------------------------------------------------------------
interface tftp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   kind;
   logic                         to_requester;
   logic [1:0]                   error_code;
   logic [tftp_pkg::BLK_W-1:0]   block_out;
   logic [tftp_pkg::LEN_W-1:0]   packet_len;
   logic                         session_open;

   modport source (
      output valid, kind, to_requester, error_code, block_out, packet_len,
             session_open,
      input  ready
   );

   modport sink (
      input  valid, kind, to_requester, error_code, block_out, packet_len,
             session_open,
      output ready
   );
endinterface

@@ rtl/tftp_in_stage.sv @@
// ----------------------------------------------------------------------------
// tftp_in_stage
// Input register: captures a request beat whenever the slot is free or drains.
// ----------------------------------------------------------------------------
module tftp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tftp_pkg::req_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tftp_pkg::req_item_type out_item
);

   logic                   valid_ff;
   logic                   valid_in;
   tftp_pkg::req_item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

@@ rtl/tftp_core.sv @@
// ----------------------------------------------------------------------------
// tftp_core
// Session state, decision logic and response register.
// ----------------------------------------------------------------------------
module tftp_core #(
   parameter int unsigned BLOCK_BYTES = tftp_pkg::BLOCK_BYTES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [tftp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tftp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  tftp_pkg::req_item_type                 in_item,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output tftp_pkg::rsp_item_type                 out_item
);

   localparam int unsigned LEN_W = tftp_pkg::LEN_W;
   localparam int unsigned BLK_W = tftp_pkg::BLK_W;
   localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(tftp_pkg::HDR_BYTES);
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(BLOCK_BYTES + tftp_pkg::HDR_BYTES);

   logic [tftp_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [tftp_pkg::RETRY_W-1:0]   max_retries_ff;

   logic                           active_ff,     active_in;
   logic                           write_mode_ff, write_mode_in;
   logic [BLK_W-1:0]               block_num_ff,  block_num_in;
   logic [LEN_W-1:0]               last_len_ff,   last_len_in;
   logic [tftp_pkg::RETRY_W-1:0]   retry_ff,      retry_in;
   logic [tftp_pkg::TIMEOUT_W-1:0] idle_ff,       idle_in;

   logic                           rsp_valid_ff;
   tftp_pkg::rsp_item_type         rsp_ff, rsp_in;

   logic                           take;
   logic [LEN_W-1:0]               data_len;
   logic [LEN_W-1:0]               plen;

   assign in_ready  = !rsp_valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

   assign data_len = LEN_W'(tftp_pkg::clamp_len(in_item.read_len, BLOCK_BYTES) + HDR_LEN);
   assign plen     = tftp_pkg::clamp_len(in_item.payload_len, BLOCK_BYTES);

   always_comb begin
      active_in     = active_ff;
      write_mode_in = write_mode_ff;
      block_num_in  = block_num_ff;
      last_len_in   = last_len_ff;
      retry_in      = retry_ff;
      idle_in       = idle_ff;
      rsp_in        = '0;
      rsp_in.kind   = tftp_pkg::KIND_NONE;

      if (in_item.command == tftp_pkg::CMD_TICK) begin
         if (!active_ff) begin
            idle_in = '0;
         end else if (idle_ff >= timeout_ff) begin
            idle_in = '0;
            if (retry_ff != tftp_pkg::RETRY_SAT) begin
               retry_in = retry_ff + 1'b1;
            end
            rsp_in.kind       = tftp_pkg::KIND_RESEND;
            rsp_in.block_out  = block_num_ff;
            rsp_in.packet_len = last_len_ff;
            if (retry_in > max_retries_ff) begin
               active_in = 1'b0;
            end
         end else begin
            idle_in = idle_ff + 1'b1;
         end
      end else begin
         case (in_item.opcode) inside
            tftp_pkg::OP_RRQ, tftp_pkg::OP_WRQ: begin
               rsp_in.to_requester = 1'b1;
               if (active_ff) begin
                  rsp_in.kind       = tftp_pkg::KIND_ERROR;
                  rsp_in.error_code = tftp_pkg::ERR_ACCESS;
               end else begin
                  block_num_in = BLK_W'(1);
                  if (!in_item.open_ok) begin
                     rsp_in.kind       = tftp_pkg::KIND_ERROR;
                     rsp_in.error_code = tftp_pkg::ERR_NOT_FOUND;
                  end else begin
                     active_in           = 1'b1;
                     retry_in            = '0;
                     idle_in             = '0;
                     last_len_in         = '0;
                     rsp_in.to_requester = 1'b0;
                     if (in_item.opcode == tftp_pkg::OP_WRQ) begin
                        write_mode_in     = 1'b1;
                        block_num_in      = '0;
                        last_len_in       = HDR_LEN;
                        rsp_in.kind       = tftp_pkg::KIND_ACK;
                        rsp_in.packet_len = HDR_LEN;
                     end else begin
                        write_mode_in = 1'b0;
                        if (!in_item.read_ok) begin
                           active_in   = 1'b0;
                           rsp_in.kind = tftp_pkg::KIND_ERROR;
                        end else begin
                           last_len_in       = data_len;
                           rsp_in.kind       = tftp_pkg::KIND_DATA;
                           rsp_in.block_out  = BLK_W'(1);
                           rsp_in.packet_len = data_len;
                        end
                     end
                  end
               end
            end
            tftp_pkg::OP_ACK: begin
               if (!active_ff || write_mode_ff) begin
                  rsp_in.kind         = tftp_pkg::KIND_ERROR;
                  rsp_in.to_requester = 1'b1;
                  rsp_in.error_code   = tftp_pkg::ERR_ACCESS;
               end else if (in_item.block != block_num_ff) begin
                  rsp_in.kind         = tftp_pkg::KIND_ERROR;
                  rsp_in.to_requester = 1'b1;
                  rsp_in.error_code   = tftp_pkg::ERR_BLOCK;
               end else if (last_len_ff == FULL_LEN) begin
                  block_num_in = block_num_ff + 1'b1;
                  if (!in_item.read_ok) begin
                     active_in   = 1'b0;
                     rsp_in.kind = tftp_pkg::KIND_ERROR;
                  end else begin
                     last_len_in       = data_len;
                     idle_in           = '0;
                     rsp_in.kind       = tftp_pkg::KIND_DATA;
                     rsp_in.block_out  = block_num_in;
                     rsp_in.packet_len = data_len;
                  end
               end else begin
                  // final short block acknowledged: close quietly
                  active_in = 1'b0;
               end
            end
            tftp_pkg::OP_DATA: begin
               if (!active_ff || !write_mode_ff) begin
                  rsp_in.kind         = tftp_pkg::KIND_ERROR;
                  rsp_in.to_requester = 1'b1;
                  rsp_in.error_code   = tftp_pkg::ERR_ACCESS;
               end else begin
                  if (!in_item.write_ok) begin
                     rsp_in.kind         = tftp_pkg::KIND_ERROR;
                     rsp_in.to_requester = 1'b1;
                     rsp_in.error_code   = tftp_pkg::ERR_ACCESS;
                     active_in           = 1'b0;
                  end else begin
                     block_num_in      = in_item.block;
                     last_len_in       = HDR_LEN;
                     idle_in           = '0;
                     rsp_in.kind       = tftp_pkg::KIND_ACK;
                     rsp_in.block_out  = in_item.block;
                     rsp_in.packet_len = HDR_LEN;
                  end
                  if (int'(plen) < int'(BLOCK_BYTES)) begin
                     active_in = 1'b0;
                  end
               end
            end
            default: begin
               rsp_in.kind         = tftp_pkg::KIND_ERROR;
               rsp_in.to_requester = 1'b1;
               rsp_in.error_code   = tftp_pkg::ERR_ILLEGAL;
            end
         endcase
      end

      rsp_in.session_open = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= tftp_pkg::TIMEOUT_RESET;
         max_retries_ff <= tftp_pkg::MAX_RETRIES_RESET;
      end else if (csr_wr_en) begin
         unique case (tftp_pkg::csr_index_type'(csr_index))
            tftp_pkg::CSR_TIMEOUT: begin
               timeout_ff <= csr_wdata[tftp_pkg::TIMEOUT_W-1:0];
            end
            tftp_pkg::CSR_MAX_RETRIES: begin
               max_retries_ff <= csr_wdata[tftp_pkg::RETRY_W-1:0];
            end
            default: begin
               timeout_ff <= timeout_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         write_mode_ff <= 1'b0;
         block_num_ff  <= '0;
         last_len_ff   <= '0;
         retry_ff      <= '0;
         idle_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            active_ff     <= active_in;
            write_mode_ff <= write_mode_in;
            block_num_ff  <= block_num_in;
            last_len_ff   <= last_len_in;
            retry_ff      <= retry_in;
            idle_ff       <= idle_in;
         end
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ rtl/tftp_single_session_server.sv @@
// ----------------------------------------------------------------------------
// tftp_single_session_server
// Single-session TFTP server control: one request beat in, one response out.
// ----------------------------------------------------------------------------
// Path: a request beat passes the input register, then decision logic into the
//   response register.
// Throughput: 1 beat per cycle while the response side is ready; the session state is updated as each beat is taken.
// Reset: synchronous; clears the session, both pipeline slots, and loads
//   timeout 5000 ticks and 5 retries.
module tftp_single_session_server #(
   parameter int unsigned BLOCK_BYTES = tftp_pkg::BLOCK_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   tftp_req_if.sink                         req_chan,
   tftp_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [tftp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tftp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tftp_pkg::req_item_type req_item;
   tftp_pkg::req_item_type stage_item;
   tftp_pkg::rsp_item_type rsp_item;
   logic                   stage_valid;
   logic                   stage_ready;

   assign req_item.command     = req_chan.command;
   assign req_item.opcode      = req_chan.opcode;
   assign req_item.block       = req_chan.block;
   assign req_item.payload_len = req_chan.payload_len;
   assign req_item.open_ok     = req_chan.open_ok;
   assign req_item.read_ok     = req_chan.read_ok;
   assign req_item.read_len    = req_chan.read_len;
   assign req_item.write_ok    = req_chan.write_ok;

   tftp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   tftp_core #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_item   (stage_item),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (rsp_item)
   );

   assign rsp_chan.kind         = rsp_item.kind;
   assign rsp_chan.to_requester = rsp_item.to_requester;
   assign rsp_chan.error_code   = rsp_item.error_code;
   assign rsp_chan.block_out    = rsp_item.block_out;
   assign rsp_chan.packet_len   = rsp_item.packet_len;
   assign rsp_chan.session_open = rsp_item.session_open;

endmodule

@@ sim/tftp_single_session_server_test.sv @@
// ----------------------------------------------------------------------------
// tftp_single_session_server_test
// Self-checking bench for the single-session TFTP server control block. A
// behavioural copy of the session logic predicts one reply for every request
// beat; replies are checked in order against it. A short directed pass covers
// the error paths, both transfer modes and the resend/drop path, then random
// session traffic runs under several timeout and retry settings, with random
// gaps on the request side and random stalls on the reply side.
// ----------------------------------------------------------------------------
module tftp_single_session_server_test;
   import tftp_pkg::*;

   localparam int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF;
   localparam logic [LEN_W-1:0] FULL_DATA_LEN = LEN_W'(BLOCK_BYTES + HDR_BYTES);
   localparam logic [LEN_W-1:0] ACK_LEN = LEN_W'(HDR_BYTES);
   localparam logic [OP_W-1:0] OP_ERROR = OP_W'(5);
   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tftp_req_if req_bus ();
   tftp_rsp_if rsp_bus ();

   tftp_single_session_server #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Session copy
   logic             sess_active;
   logic             sess_write;
   logic [BLK_W-1:0] sess_block;
   logic [LEN_W-1:0] sess_last_len;
   logic             sess_last_data;
   logic [RETRY_W-1:0] sess_retries;
   logic [TIMEOUT_W-1:0] sess_idle;
   logic [TIMEOUT_W-1:0] cfg_timeout;
   logic [RETRY_W-1:0] cfg_max_retries;

   rsp_item_type replies_due[$];
   rsp_item_type seen_reply;
   rsp_item_type want_reply;

   int unsigned mismatches = 0;
   int unsigned beats_sent = 0;
   int unsigned replies_seen = 0;
   int unsigned resends_seen = 0;
   int unsigned settings_used = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   bit          stalls_on = 1'b0;

   function automatic logic [LEN_W-1:0] fit_len(input logic [LEN_W-1:0] v);
      return (v > LEN_W'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES) : v;
   endfunction

   function automatic rsp_item_type reject(input logic [1:0] code);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.to_requester = 1'b1;
      r.error_code = code;
      return r;
   endfunction

   function automatic rsp_item_type ack_reply(input logic [BLK_W-1:0] blk);
      rsp_item_type r;
      r = '0;
      sess_block = blk;
      sess_last_len = ACK_LEN;
      sess_last_data = 1'b0;
      sess_idle = '0;
      r.kind = KIND_ACK;
      r.block_out = blk;
      r.packet_len = ACK_LEN;
      return r;
   endfunction

   // A failed read closes the session and reports to the session peer.
   function automatic rsp_item_type data_reply(input logic ok, input logic [LEN_W-1:0] rlen);
      rsp_item_type r;
      r = '0;
      if (!ok) begin
         sess_active = 1'b0;
         r.kind = KIND_ERROR;
         r.error_code = ERR_ACCESS;
      end else begin
         sess_last_len = fit_len(rlen) + LEN_W'(HDR_BYTES);
         sess_last_data = 1'b1;
         sess_idle = '0;
         r.kind = KIND_DATA;
         r.block_out = sess_block;
         r.packet_len = sess_last_len;
      end
      return r;
   endfunction

   function automatic rsp_item_type server_reply(input req_item_type it);
      rsp_item_type r;
      r = '0;
      if (it.command == CMD_TICK) begin
         if (!sess_active) begin
            sess_idle = '0;
         end else if (sess_idle >= cfg_timeout) begin
            sess_idle = '0;
            if (sess_retries != RETRY_SAT) begin
               sess_retries = sess_retries + 1'b1;
            end
            r.kind = KIND_RESEND;
            r.block_out = sess_block;
            r.packet_len = sess_last_len;
            if (sess_retries > cfg_max_retries) begin
               sess_active = 1'b0;
            end
         end else begin
            sess_idle = sess_idle + 1'b1;
         end
      end else if (it.opcode == OP_RRQ || it.opcode == OP_WRQ) begin
         if (sess_active) begin
            r = reject(ERR_ACCESS);
         end else begin
            sess_block = BLK_W'(1);
            if (!it.open_ok) begin
               r = reject(ERR_NOT_FOUND);
            end else begin
               sess_active = 1'b1;
               sess_retries = '0;
               sess_idle = '0;
               sess_last_len = '0;
               sess_write = (it.opcode == OP_WRQ);
               if (sess_write) begin
                  r = ack_reply('0);
               end else begin
                  r = data_reply(it.read_ok, it.read_len);
               end
            end
         end
      end else if (it.opcode == OP_ACK) begin
         if (!sess_active || sess_write) begin
            r = reject(ERR_ACCESS);
         end else if (it.block != sess_block) begin
            r = reject(ERR_BLOCK);
         end else if (sess_last_len == FULL_DATA_LEN) begin
            sess_block = sess_block + 1'b1;
            r = data_reply(it.read_ok, it.read_len);
         end else begin
            // short final block acknowledged: close quietly
            sess_active = 1'b0;
         end
      end else if (it.opcode == OP_DATA) begin
         if (!sess_active || !sess_write) begin
            r = reject(ERR_ACCESS);
         end else begin
            if (!it.write_ok) begin
               r = reject(ERR_ACCESS);
               sess_active = 1'b0;
            end else begin
               r = ack_reply(it.block);
            end
            if (fit_len(it.payload_len) < LEN_W'(BLOCK_BYTES)) begin
               sess_active = 1'b0;
            end
         end
      end else begin
         r = reject(ERR_ILLEGAL);
      end
      r.session_open = sess_active;
      return r;
   endfunction

   function automatic string fmt_reply(input rsp_item_type r);
      return $sformatf("kind=%0d req=%0d code=%0d blk=%h len=%0d open=%0d",
                       r.kind, r.to_requester, r.error_code, r.block_out,
                       r.packet_len, r.session_open);
   endfunction

   task automatic log_mismatch(input string what, input rsp_item_type want,
                               input rsp_item_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("MISMATCH %0d, %s: expected %s", mismatches, what, fmt_reply(want));
         $display("               actual   %s", fmt_reply(got));
      end
   endtask

   // Reply checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_reply.kind = rsp_bus.kind;
         seen_reply.to_requester = rsp_bus.to_requester;
         seen_reply.error_code = rsp_bus.error_code;
         seen_reply.block_out = rsp_bus.block_out;
         seen_reply.packet_len = rsp_bus.packet_len;
         seen_reply.session_open = rsp_bus.session_open;
         replies_seen++;
         if (seen_reply.kind == KIND_RESEND) begin
            resends_seen++;
         end
         if (replies_due.size() == 0) begin
            log_mismatch("reply with none pending", '0, seen_reply);
         end else begin
            want_reply = replies_due.pop_front();
            if (seen_reply !== want_reply) begin
               log_mismatch($sformatf("reply %0d", replies_seen), want_reply, seen_reply);
            end
         end
      end
   end

   // Reply-side back-pressure in random bursts; ends at once when switched off
   always @(posedge clock) begin
      if (!stalls_on) begin
         rsp_bus.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                     QUIET_LIMIT, replies_due.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_req(input req_item_type it);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= it.command;
      req_bus.opcode <= it.opcode;
      req_bus.block <= it.block;
      req_bus.payload_len <= it.payload_len;
      req_bus.open_ok <= it.open_ok;
      req_bus.read_ok <= it.read_ok;
      req_bus.read_len <= it.read_len;
      req_bus.write_ok <= it.write_ok;
      do @(posedge clock); while (!req_bus.ready);
      replies_due.push_back(server_reply(it));
      beats_sent++;
   endtask

   function automatic req_item_type make_pkt(input logic [OP_W-1:0] op,
                                             input logic [BLK_W-1:0] blk,
                                             input logic [LEN_W-1:0] plen,
                                             input logic open_ok,
                                             input logic read_ok,
                                             input logic [LEN_W-1:0] rlen,
                                             input logic write_ok);
      req_item_type it;
      it.command = CMD_PACKET;
      it.opcode = op;
      it.block = blk;
      it.payload_len = plen;
      it.open_ok = open_ok;
      it.read_ok = read_ok;
      it.read_len = rlen;
      it.write_ok = write_ok;
      return it;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.command = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) begin
         it.opcode = OP_W'($urandom);
      end else begin
         it.opcode = OP_W'($urandom_range(0, 6));
      end
      it.block = BLK_W'($urandom);
      it.payload_len = LEN_W'($urandom);
      it.open_ok = 1'($urandom_range(0, 1));
      it.read_ok = 1'($urandom_range(0, 1));
      it.read_len = LEN_W'($urandom);
      it.write_ok = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Mostly full blocks so transfers run on; some oversized, some short.
   function automatic logic [LEN_W-1:0] pick_len();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return LEN_W'(BLOCK_BYTES);
      else if (roll == 7) return LEN_W'($urandom_range(BLOCK_BYTES + 1, 1023));
      else return LEN_W'($urandom_range(0, BLOCK_BYTES - 1));
   endfunction

   task automatic send_ticks(input int unsigned n);
      req_item_type it;
      repeat (n) begin
         it = random_item();
         it.command = CMD_TICK;
         send_req(it);
      end
   endtask

   // Drop valid, drain all replies, then wait out the pipeline.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [TIMEOUT_W-1:0] ticks_limit,
                               input logic [RETRY_W-1:0] retries);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= CSR_DATA_W'(ticks_limit);
      @(posedge clock);
      cfg_timeout = ticks_limit;
      csr_index <= CSR_MAX_RETRIES;
      csr_wdata <= CSR_DATA_W'(retries);
      @(posedge clock);
      cfg_max_retries = retries;
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic test_read_path();
      send_ticks(1);
      send_req(make_pkt(OP_RRQ, 16'h0000, 10'd0, 1'b0, 1'b1, 10'd512, 1'b1));
      send_req(make_pkt(OP_RRQ, 16'hFFFF, 10'd1023, 1'b1, 1'b1, 10'd1023, 1'b0));
      send_req(make_pkt(OP_WRQ, 16'h0000, 10'd0, 1'b1, 1'b1, 10'd512, 1'b1));
      send_req(make_pkt(OP_ACK, 16'h0002, 10'd0, 1'b1, 1'b1, 10'd512, 1'b1));
      send_req(make_pkt(OP_DATA, 16'h0001, 10'd512, 1'b1, 1'b1, 10'd512, 1'b1));
      send_req(make_pkt(OP_ACK, 16'h0001, 10'd0, 1'b0, 1'b1, 10'd0, 1'b0));
      send_ticks(2);
      send_req(make_pkt(OP_ACK, 16'h0002, 10'd0, 1'b0, 1'b1, 10'd512, 1'b0));
      send_req(make_pkt(OP_ACK, 16'h0003, 10'd0, 1'b1, 1'b1, 10'd512, 1'b1));
      send_req(make_pkt(OP_RRQ, 16'h1234, 10'd0, 1'b1, 1'b0, 10'd512, 1'b1));
   endtask

   task automatic test_write_path();
      send_req(make_pkt(OP_WRQ, 16'h5555, 10'd0, 1'b1, 1'b0, 10'd0, 1'b0));
      send_req(make_pkt(OP_DATA, 16'hFFFF, 10'd512, 1'b0, 1'b0, 10'd0, 1'b1));
      send_req(make_pkt(OP_ACK, 16'h0000, 10'd0, 1'b1, 1'b1, 10'd512, 1'b1));
      send_req(make_pkt(OP_DATA, 16'h0000, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b1));
      send_req(make_pkt(OP_DATA, 16'h0001, 10'd512, 1'b0, 1'b0, 10'd0, 1'b0));
      send_req(make_pkt(OP_DATA, 16'h0002, 10'd512, 1'b0, 1'b0, 10'd0, 1'b1));
      send_req(make_pkt(OP_WRQ, 16'h0000, 10'd0, 1'b1, 1'b1, 10'd0, 1'b1));
      send_req(make_pkt(OP_DATA, 16'hAAAA, 10'd0, 1'b1, 1'b1, 10'd0, 1'b1));
   endtask

   task automatic test_illegal_ops();
      send_req(make_pkt(16'h0000, 16'h0000, 10'd0, 1'b1, 1'b1, 10'd0, 1'b1));
      send_req(make_pkt(OP_ERROR, 16'h0001, 10'd0, 1'b1, 1'b1, 10'd0, 1'b1));
      send_req(make_pkt(16'hFFFF, 16'hFFFF, 10'd1023, 1'b1, 1'b1, 10'd1023, 1'b1));
   endtask

   // Timeout of one tick, one retry: two resends, the second drops the session.
   task automatic test_resend_drop();
      settle();
      write_config(TIMEOUT_W'(1), RETRY_W'(1));
      send_req(make_pkt(OP_WRQ, 16'h0000, 10'd0, 1'b1, 1'b1, 10'd0, 1'b1));
      send_ticks(5);
   endtask

   // Retry limit at 254, one below saturation: the count climbs until it passes the limit.
   task automatic test_retry_saturation();
      settle();
      write_config(TIMEOUT_W'(1), RETRY_W'(254));
      gap_pct = 10;
      stalls_on = 1'b1;
      send_req(make_pkt(OP_RRQ, 16'h0000, 10'd0, 1'b1, 1'b1, 10'd512, 1'b1));
      while (sess_active) send_ticks(1);
      send_ticks(2);
   endtask

   task automatic run_traffic(input int unsigned n_items);
      req_item_type it;
      int unsigned roll;
      repeat (n_items) begin
         it = random_item();
         roll = $urandom_range(0, 99);
         if (!sess_active) begin
            if (roll < 70) begin
               it.command = CMD_PACKET;
               it.opcode = ($urandom_range(0, 1) != 0) ? OP_RRQ : OP_WRQ;
               it.open_ok = ($urandom_range(0, 9) != 0);
               it.read_ok = ($urandom_range(0, 19) != 0);
               it.read_len = pick_len();
            end else if (roll < 80) begin
               it.command = CMD_TICK;
            end
         end else begin
            if (roll < 25) begin
               it.command = CMD_TICK;
            end else if (roll < 85) begin
               it.command = CMD_PACKET;
               if (sess_write) begin
                  it.opcode = OP_DATA;
                  it.block = sess_block + 1'b1;
                  it.payload_len = pick_len();
                  it.write_ok = ($urandom_range(0, 19) != 0);
               end else begin
                  it.opcode = OP_ACK;
                  it.block = sess_block;
                  it.read_ok = ($urandom_range(0, 19) != 0);
                  it.read_len = pick_len();
               end
            end else if (roll < 90) begin
               it.command = CMD_PACKET;
               it.opcode = OP_ACK;
            end
         end
         send_req(it);
      end
   endtask

   task automatic test_random_sessions(input int unsigned n_phases);
      logic [TIMEOUT_W-1:0] ticks_limit;
      logic [RETRY_W-1:0] retries;
      for (int unsigned p = 0; p < n_phases; p++) begin
         case (p)
            0: begin
               ticks_limit = '1;
               retries = RETRY_W'(254);
            end
            1: begin
               ticks_limit = TIMEOUT_W'(1);
               retries = '0;
            end
            default: begin
               ticks_limit = TIMEOUT_W'($urandom_range(1, 12));
               retries = RETRY_W'($urandom_range(0, 6));
            end
         endcase
         settle();
         write_config(ticks_limit, retries);
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 30;
         endcase
         stalls_on = 1'($urandom_range(0, 1));
         run_traffic(115);
      end
   endtask

   // Last stretch runs back to back on both sides.
   task automatic test_full_rate();
      settle();
      write_config(TIMEOUT_W'(3), RETRY_W'(2));
      gap_pct = 0;
      stalls_on = 1'b0;
      run_traffic(120);
   endtask

   initial begin
      sess_active = 1'b0;
      sess_write = 1'b0;
      sess_block = '0;
      sess_last_len = '0;
      sess_last_data = 1'b0;
      sess_retries = '0;
      sess_idle = '0;
      cfg_timeout = TIMEOUT_RESET;
      cfg_max_retries = MAX_RETRIES_RESET;

      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_PACKET;
      req_bus.opcode <= '0;
      req_bus.block <= '0;
      req_bus.payload_len <= '0;
      req_bus.open_ok <= 1'b0;
      req_bus.read_ok <= 1'b0;
      req_bus.read_len <= '0;
      req_bus.write_ok <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_read_path();
      test_write_path();
      test_illegal_ops();
      test_resend_drop();
      test_random_sessions(6);
      test_retry_saturation();
      test_full_rate();

      settle();
      $display("Covered %0d request beats and %0d replies (%0d resends) over %0d settings,",
               beats_sent, replies_seen, resends_seen, settings_used);
      $display("both transfer modes, error paths, session drop and retry limit at 254.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
